[rtl/core/kmsed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kmsed_pkg;

  // Matrix geometry and key list size
  localparam int NUM_ROWS   = 8;
  localparam int NUM_COLS   = 7;
  localparam int ROW_STRIDE = 14;   // codes per row pair group
  localparam int HALF_ROWS  = 4;
  localparam int MAX_KEYS   = 8;

  localparam int ROW_W     = $clog2(NUM_ROWS);
  localparam int COL_W     = $clog2(NUM_COLS);
  localparam int CODE_W    = 6;
  localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

  localparam logic [ROW_W-1:0] FIRST_ROW = '0;
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(NUM_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(NUM_COLS - 1);

  // One row sample
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [NUM_COLS-1:0] col_levels;
  } in_item_t;

  // One key event
  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic              is_press;
    logic              last;
  } out_item_t;

  // Request from the sequencer to the event output stage
  typedef struct packed {
    logic              push;
    logic              flush;
    logic [CODE_W-1:0] key_code;
    logic              is_press;
  } evt_req_t;

  // Result of one step of the shared compare unit
  typedef struct packed {
    logic hit;
    logic exhausted;
  } match_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_APPEND = 5'b00010,
    ST_REL    = 5'b00100,
    ST_PRS    = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

[rtl/core/kmsed_key_code.sv]
`timescale 1ns / 1ps
`default_nettype none

module kmsed_key_code (
  input  wire logic [kmsed_pkg::ROW_W-1:0]  row,
  input  wire logic [kmsed_pkg::COL_W-1:0]  col,
  output logic      [kmsed_pkg::CODE_W-1:0] key_code
);

  logic [1:0]                    row_grp;
  logic [kmsed_pkg::CODE_W-1:0]  grp_base;
  logic [kmsed_pkg::CODE_W-1:0]  col_off;
  logic                          upper_half;

  // code = (3 - row mod 4) * 14 + col * 2 + (row < 4) + 1
  always_comb begin
    row_grp    = 2'(kmsed_pkg::HALF_ROWS - 1) - row[1:0];
    grp_base   = kmsed_pkg::CODE_W'(row_grp) * kmsed_pkg::CODE_W'(kmsed_pkg::ROW_STRIDE);
    col_off    = kmsed_pkg::CODE_W'({col, 1'b0});
    upper_half = (row < kmsed_pkg::ROW_W'(kmsed_pkg::HALF_ROWS));
    key_code   = grp_base + col_off + kmsed_pkg::CODE_W'(upper_half) + kmsed_pkg::CODE_W'(1);
  end

endmodule

`default_nettype wire

[rtl/core/kmsed_match_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module kmsed_match_unit (
  input  wire logic [kmsed_pkg::CODE_W-1:0]    probe,
  input  wire logic [kmsed_pkg::CODE_W-1:0]    entry,
  input  wire logic [kmsed_pkg::KEY_CNT_W-1:0] entry_idx,
  input  wire logic [kmsed_pkg::KEY_CNT_W-1:0] entry_cnt,
  output kmsed_pkg::match_t                    result
);

  // Shared compare: is the list walk finished, and if not, does this entry match
  always_comb begin
    result.exhausted = (entry_idx == entry_cnt);
    result.hit       = !result.exhausted && (probe == entry);
  end

endmodule

`default_nettype wire

[rtl/core/kmsed_event_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module kmsed_event_out (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire kmsed_pkg::evt_req_t  req,
  output logic                      req_ready,
  output logic                      key_evt_valid,
  input  wire logic                 key_evt_ready,
  output kmsed_pkg::out_item_t      key_evt
);

  logic                         pend_valid;
  logic [kmsed_pkg::CODE_W-1:0] pend_code;
  logic                         pend_press;
  logic                         out_free;
  logic                         move_out;

  // One event is held back so the final one can carry the last flag
  always_comb begin
    out_free  = !key_evt_valid || key_evt_ready;
    req_ready = !pend_valid || out_free;
    move_out  = (req.push || req.flush) && pend_valid && out_free;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      key_evt_valid <= 1'b0;
    end else begin
      if (key_evt_valid && key_evt_ready) begin
        key_evt_valid <= 1'b0;
      end
      if (move_out) begin
        key_evt_valid <= 1'b1;
      end
      if (req.push && req_ready) begin
        pend_valid <= 1'b1;
      end else if (req.flush && req_ready) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (move_out) begin
      key_evt.key_code <= pend_code;
      key_evt.is_press <= pend_press;
      key_evt.last     <= req.flush;
    end
    if (req.push && req_ready) begin
      pend_code  <= req.key_code;
      pend_press <= req.is_press;
    end
  end

endmodule

`default_nettype wire

[rtl/core/key_matrix_scan_event_diff_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Key matrix scanner with press/release event diff.
// Input channel row_sample: one row of an 8x7 matrix (row index, active-low
// column levels), rows sent 0 to 7; row 0 restarts the current key list.
// Output channel key_evt: key code, press/release, and a last flag on the
// final event of a scan. Releases come first, then presses.
// Sequence: a row request is accepted in idle, then takes 7 column steps (one
// column per cycle through the key code unit). Row 7 then walks both lists
// through one shared comparator, one compare per cycle while no output stall
// holds it, and row_ready returns after both walks and the flush.
// Each event is moved to the key_evt register, once the output is free,
// when the next event is found or the scan ends; the newest is held back
// until then to decide its last flag. A stall on key_evt_ready pauses the
// list walk when an event is waiting; no event is dropped. row_ready is
// high only while the sequencer is idle. Reset clears both key counts and
// the output stage; list contents are never read before being written.
module key_matrix_scan_event_diff_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 row_valid,
  output logic                      row_ready,
  input  wire kmsed_pkg::in_item_t  row_sample,
  output logic                      key_evt_valid,
  input  wire logic                 key_evt_ready,
  output kmsed_pkg::out_item_t      key_evt
);

  kmsed_pkg::state_t                 state;
  kmsed_pkg::state_t                 state_next;
  logic [kmsed_pkg::ROW_W-1:0]       row_q;
  logic [kmsed_pkg::NUM_COLS-1:0]    cols_q;
  logic [kmsed_pkg::COL_W-1:0]       col_idx;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   cur_count;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   prev_count;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   idx_i;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   idx_j;
  logic [kmsed_pkg::CODE_W-1:0]      cur_keys  [kmsed_pkg::MAX_KEYS];
  logic [kmsed_pkg::CODE_W-1:0]      prev_keys [kmsed_pkg::MAX_KEYS];

  logic [kmsed_pkg::CODE_W-1:0]      new_code;
  logic                              key_hit;
  logic                              list_full;
  logic                              in_rel;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   prev_addr;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   cur_addr;
  logic [kmsed_pkg::CODE_W-1:0]      prev_rd;
  logic [kmsed_pkg::CODE_W-1:0]      cur_rd;
  logic [kmsed_pkg::CODE_W-1:0]      probe;
  logic [kmsed_pkg::CODE_W-1:0]      entry;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   outer_cnt;
  logic [kmsed_pkg::KEY_CNT_W-1:0]   inner_cnt;
  logic                              outer_done;
  logic                              scanning;
  kmsed_pkg::match_t                 match;
  kmsed_pkg::evt_req_t               req;
  logic                              req_ready;

  assign row_ready = (state == kmsed_pkg::ST_IDLE);

  // Key code of the column under the append pointer
  kmsed_key_code u_key_code (
    .row      (row_q),
    .col      (col_idx),
    .key_code (new_code)
  );

  always_comb begin
    key_hit   = !cols_q[col_idx];
    list_full = (cur_count >= kmsed_pkg::KEY_CNT_W'(kmsed_pkg::MAX_KEYS));
  end

  // List read ports: releases walk prev (outer) against cur (inner),
  // presses walk cur against prev
  always_comb begin
    in_rel     = (state == kmsed_pkg::ST_REL);
    scanning   = (state == kmsed_pkg::ST_REL) || (state == kmsed_pkg::ST_PRS);
    prev_addr  = in_rel ? idx_i : idx_j;
    cur_addr   = in_rel ? idx_j : idx_i;
    prev_rd    = prev_keys[prev_addr[kmsed_pkg::KEY_IDX_W-1:0]];
    cur_rd     = cur_keys[cur_addr[kmsed_pkg::KEY_IDX_W-1:0]];
    probe      = in_rel ? prev_rd : cur_rd;
    entry      = in_rel ? cur_rd : prev_rd;
    outer_cnt  = in_rel ? prev_count : cur_count;
    inner_cnt  = in_rel ? cur_count : prev_count;
    outer_done = (idx_i == outer_cnt);
  end

  kmsed_match_unit u_match (
    .probe     (probe),
    .entry     (entry),
    .entry_idx (idx_j),
    .entry_cnt (inner_cnt),
    .result    (match)
  );

  // Event request: push an outer key found nowhere in the inner list, flush in ST_FLUSH
  always_comb begin
    req.push     = scanning && !outer_done && match.exhausted;
    req.flush    = (state == kmsed_pkg::ST_FLUSH);
    req.key_code = probe;
    req.is_press = !in_rel;
  end

  kmsed_event_out u_event_out (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .req_ready     (req_ready),
    .key_evt_valid (key_evt_valid),
    .key_evt_ready (key_evt_ready),
    .key_evt       (key_evt)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      kmsed_pkg::ST_IDLE: begin
        if (row_valid) begin
          state_next = kmsed_pkg::ST_APPEND;
        end
      end
      kmsed_pkg::ST_APPEND: begin
        if (col_idx == kmsed_pkg::LAST_COL) begin
          state_next = (row_q == kmsed_pkg::LAST_ROW) ? kmsed_pkg::ST_REL
                                                      : kmsed_pkg::ST_IDLE;
        end
      end
      kmsed_pkg::ST_REL: begin
        if (outer_done) begin
          state_next = kmsed_pkg::ST_PRS;
        end
      end
      kmsed_pkg::ST_PRS: begin
        if (outer_done) begin
          state_next = kmsed_pkg::ST_FLUSH;
        end
      end
      kmsed_pkg::ST_FLUSH: begin
        if (req_ready) begin
          state_next = kmsed_pkg::ST_IDLE;
        end
      end
      default: state_next = kmsed_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kmsed_pkg::ST_IDLE;
      col_idx    <= '0;
      cur_count  <= '0;
      prev_count <= '0;
      idx_i      <= '0;
      idx_j      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        kmsed_pkg::ST_IDLE: begin
          col_idx <= '0;
          if (row_valid && (row_sample.row == kmsed_pkg::FIRST_ROW)) begin
            cur_count <= '0;
          end
        end
        kmsed_pkg::ST_APPEND: begin
          col_idx <= col_idx + kmsed_pkg::COL_W'(1);
          idx_i   <= '0;
          idx_j   <= '0;
          if (key_hit && !list_full) begin
            cur_count <= cur_count + kmsed_pkg::KEY_CNT_W'(1);
          end
        end
        kmsed_pkg::ST_REL, kmsed_pkg::ST_PRS: begin
          priority if (outer_done) begin
            idx_i <= '0;
            idx_j <= '0;
          end else if (match.exhausted) begin
            if (req_ready) begin
              idx_i <= idx_i + kmsed_pkg::KEY_CNT_W'(1);
              idx_j <= '0;
            end
          end else if (match.hit) begin
            idx_i <= idx_i + kmsed_pkg::KEY_CNT_W'(1);
            idx_j <= '0;
          end else begin
            idx_j <= idx_j + kmsed_pkg::KEY_CNT_W'(1);
          end
        end
        kmsed_pkg::ST_FLUSH: begin
          if (req_ready) begin
            prev_count <= cur_count;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: row sample and both key lists
  always_ff @(posedge clk) begin
    if (row_valid && row_ready) begin
      row_q  <= row_sample.row;
      cols_q <= row_sample.col_levels;
    end
    if ((state == kmsed_pkg::ST_APPEND) && key_hit && !list_full) begin
      cur_keys[cur_count[kmsed_pkg::KEY_IDX_W-1:0]] <= new_code;
    end
    if ((state == kmsed_pkg::ST_FLUSH) && req_ready) begin
      prev_keys <= cur_keys;
    end
  end

  // Checks
  a_cur_count_bound: assert property (@(posedge clk) disable iff (rst)
    cur_count <= kmsed_pkg::KEY_CNT_W'(kmsed_pkg::MAX_KEYS))
    else $error("current key count past list size");

  a_evt_code_range: assert property (@(posedge clk) disable iff (rst)
    key_evt_valid |-> (key_evt.key_code != '0) &&
                      (key_evt.key_code <= kmsed_pkg::CODE_W'(
                         kmsed_pkg::NUM_ROWS * kmsed_pkg::NUM_COLS)))
    else $error("event key code out of range");

  a_list_handover: assert property (@(posedge clk) disable iff (rst)
    (state == kmsed_pkg::ST_FLUSH && req_ready) |=> prev_count == $past(cur_count))
    else $error("previous list count not taken over at end of scan");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    scanning |-> !row_ready)
    else $error("row request accepted during list walk");

endmodule

`default_nettype wire
